[rtl/lnti_pkg.sv]
package lnti_pkg;

  // Number of reference levels and the fixed candidate indices.
  localparam int unsigned NumLevels   = 8;
  localparam int unsigned LevelIdxW   = 3;
  localparam logic [7:0]  FirstTint   = 8'd174;

  // Luma weights.
  localparam logic [14:0] WeightRed   = 15'd30;
  localparam logic [14:0] WeightGreen = 15'd60;
  localparam logic [14:0] WeightBlue  = 15'd10;

  // Division by 100 as a multiplication by ceil(2^19 / 100) and a shift.
  // The error stays below 0.006 for weighted sums up to 25500, so the
  // truncated quotient is exact.
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int unsigned RecipShift   = 19;

  typedef logic [7:0]  luma_t;
  typedef logic [14:0] wsum_t;
  typedef logic [NumLevels-1:0][7:0] level_vec_t;
  typedef logic [NumLevels-1:0][7:0] dist_vec_t;

  // A candidate that has survived part of the comparison tree.
  typedef struct packed {
    logic [LevelIdxW-1:0] idx;
    logic [7:0]           diff;
  } cand_t;

  // Palette index of candidate n: groups of two, 16 entries apart.
  function automatic logic [7:0] candidate_index(logic [LevelIdxW-1:0] n);
    logic [7:0] group_off;
    group_off = {2'b00, n[2:1], 4'b0000};
    return FirstTint + group_off + {7'd0, n[0]};
  endfunction

  // Keeps the earlier candidate unless the later one is strictly closer.
  function automatic cand_t pick(cand_t early, cand_t late);
    return (late.diff < early.diff) ? late : early;
  endfunction

endpackage

[rtl/luma_nearest_tint_index_core.sv]
// Nearest tint by brightness for one palette colour.
// Input stream: each word carries red, green and blue; output stream: each
// word carries the chosen palette index and the luma (30r+60g+10b)/100.
// The index is the one of 174, 175, 190, 191, 206, 207, 222 and 223 whose
// reference level lies closest to the luma; the earlier one wins a tie.
// The eight levels are written through the configuration port, index 0 to
// 7 in that order, and should only change while no word is in flight.
// The pipeline has five registered stages: weighted sum, division by one
// hundred, level distances, and two comparison tree stages. One word is
// accepted per cycle while the receiver does not stall; each of the five
// pipeline registers holds one word.
// Reset clears all valid bits and sets every level to zero.
// When the receiver stalls, each stage keeps its word and fills up behind
// the stalled output; s_axis_tready falls only once all five stages hold a
// word, and nothing is lost or repeated.
module luma_nearest_tint_index_core
  import lnti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // tint_index [7:0], luma [15:8]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i
);

  level_vec_t levels_q;
  logic       luma_valid, luma_ready;
  luma_t      luma;
  logic       dist_valid, dist_ready;
  luma_t      dist_luma;
  dist_vec_t  level_diff;
  logic [7:0] tint_index;
  luma_t      out_luma;

  // Reference level registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= '0;
    end else if (cfg_we_i) begin
      levels_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  lnti_luma u_luma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (luma_valid),
    .ready_i (luma_ready),
    .luma_o  (luma)
  );

  lnti_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (luma_valid),
    .ready_o  (luma_ready),
    .luma_i   (luma),
    .levels_i (levels_q),
    .valid_o  (dist_valid),
    .ready_i  (dist_ready),
    .luma_o   (dist_luma),
    .dist_o   (level_diff)
  );

  lnti_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (dist_valid),
    .ready_o      (dist_ready),
    .luma_i       (dist_luma),
    .dist_i       (level_diff),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .tint_index_o (tint_index),
    .luma_o       (out_luma)
  );

  assign m_axis_tdata = {out_luma, tint_index};

  // An empty output stage means the whole pipeline can take a word.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready although the output stage is empty");

  // Every result names one of the eight candidate indices.
  a_index_is_candidate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd174 || m_axis_tdata[7:0] == 8'd175 ||
                       m_axis_tdata[7:0] == 8'd190 || m_axis_tdata[7:0] == 8'd191 ||
                       m_axis_tdata[7:0] == 8'd206 || m_axis_tdata[7:0] == 8'd207 ||
                       m_axis_tdata[7:0] == 8'd222 || m_axis_tdata[7:0] == 8'd223))
    else $error("result index is not a candidate");

  // A write to level register 0 lands in the next cycle.
  a_level_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_addr_i == 3'd0 |=> levels_q[0] == $past(cfg_wdata_i))
    else $error("level register write lost");

endmodule

[rtl/lnti_luma.sv]
module lnti_luma
  import lnti_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       valid_o,
  input  logic       ready_i,
  output luma_t      luma_o
);

  logic  sum_valid_q, luma_valid_q;
  logic  sum_ready, luma_ready;
  wsum_t sum_d, sum_q;
  luma_t luma_d, luma_q;
  logic [27:0] prod;

  // A stage takes a new word when it is empty or its word moves on.
  assign luma_ready = !luma_valid_q || ready_i;
  assign sum_ready  = !sum_valid_q || luma_ready;
  assign ready_o    = sum_ready;

  // First stage: weighted sum of the three components.
  assign sum_d = WeightRed * 15'(red_i) + WeightGreen * 15'(green_i)
               + WeightBlue * 15'(blue_i);

  // Second stage: divide the sum by one hundred.
  assign prod   = 28'(sum_q) * 28'(RecipHundred);
  assign luma_d = prod[RecipShift +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q  <= 1'b0;
      luma_valid_q <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid_q <= valid_i;
      end
      if (luma_ready) begin
        luma_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && sum_ready) begin
      sum_q <= sum_d;
    end
    if (sum_valid_q && luma_ready) begin
      luma_q <= luma_d;
    end
  end

  assign valid_o = luma_valid_q;
  assign luma_o  = luma_q;

endmodule

[rtl/lnti_dist.sv]
module lnti_dist
  import lnti_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  luma_t      luma_i,
  input  level_vec_t levels_i,
  output logic       valid_o,
  input  logic       ready_i,
  output luma_t      luma_o,
  output dist_vec_t  dist_o
);

  logic      valid_q;
  luma_t     luma_q;
  dist_vec_t dist_d, dist_q;

  assign ready_o = !valid_q || ready_i;

  // Absolute difference between the luma and every reference level.
  always_comb begin
    for (int n = 0; n < NumLevels; n++) begin
      dist_d[n] = (levels_i[n] >= luma_i) ? (levels_i[n] - luma_i)
                                          : (luma_i - levels_i[n]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      luma_q <= luma_i;
      dist_q <= dist_d;
    end
  end

  assign valid_o = valid_q;
  assign luma_o  = luma_q;
  assign dist_o  = dist_q;

endmodule

[rtl/lnti_select.sv]
module lnti_select
  import lnti_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  luma_t      luma_i,
  input  dist_vec_t  dist_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] tint_index_o,
  output luma_t      luma_o
);

  logic        half_valid_q, out_valid_q;
  logic        half_ready, out_ready;
  cand_t [3:0] leaf;
  cand_t [1:0] half_d, half_q;
  cand_t       best;
  luma_t       half_luma_q, luma_q;
  logic [7:0]  index_q;

  assign out_ready  = !out_valid_q || ready_i;
  assign half_ready = !half_valid_q || out_ready;
  assign ready_o    = half_ready;

  // First tree stage: eight candidates down to two, earlier wins on a tie.
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      leaf[p] = pick('{idx: LevelIdxW'(2 * p),     diff: dist_i[2 * p]},
                     '{idx: LevelIdxW'(2 * p + 1), diff: dist_i[2 * p + 1]});
    end
    half_d[0] = pick(leaf[0], leaf[1]);
    half_d[1] = pick(leaf[2], leaf[3]);
  end

  // Second tree stage: final choice, mapped to its palette index.
  assign best = pick(half_q[0], half_q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (half_ready) begin
        half_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= half_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && half_ready) begin
      half_q      <= half_d;
      half_luma_q <= luma_i;
    end
    if (half_valid_q && out_ready) begin
      index_q <= candidate_index(best.idx);
      luma_q  <= half_luma_q;
    end
  end

  assign valid_o      = out_valid_q;
  assign tint_index_o = index_q;
  assign luma_o       = luma_q;

endmodule
